[hw/rtl/tstr_pkg.sv]
package tstr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam int THRESH_BITS  = 12;
   localparam int DIV_BITS     = 8;
   localparam int MS_CFG_BITS  = 16;
   localparam int TIME_BITS    = 32;
   localparam int EVENT_BITS   = 3;
   localparam int CSR_IDX_BITS = 8;
   localparam int CSR_DAT_BITS = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_SWIPE_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_REPEAT_DIVISOR  = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TAP_MIN_MS      = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LONG_PRESS_MS   = 8'd3;

   // register reset values
   localparam logic [THRESH_BITS-1:0] SWIPE_THRESHOLD_RST = 12'd20;
   localparam logic [DIV_BITS-1:0]    REPEAT_DIVISOR_RST  = 8'd5;
   localparam logic [MS_CFG_BITS-1:0] TAP_MIN_MS_RST      = 16'd50;
   localparam logic [MS_CFG_BITS-1:0] LONG_PRESS_MS_RST   = 16'd500;

   // event codes
   localparam logic [EVENT_BITS-1:0] EV_NONE  = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_UP    = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_DOWN  = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_LEFT  = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_RIGHT = 3'd4;
   localparam logic [EVENT_BITS-1:0] EV_TAP   = 3'd5;
   localparam logic [EVENT_BITS-1:0] EV_LONG  = 3'd6;

   typedef struct packed {
      logic [THRESH_BITS-1:0] swipe_threshold;
      logic [DIV_BITS-1:0]    repeat_divisor;
      logic [MS_CFG_BITS-1:0] tap_min_ms;
      logic [MS_CFG_BITS-1:0] long_press_ms;
   } cfg_type;

endpackage

[hw/rtl/tstr_csr.sv]
module tstr_csr import tstr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SWIPE_THRESHOLD: cfg_in.swipe_threshold = csr_data[THRESH_BITS-1:0];
            REG_REPEAT_DIVISOR:  cfg_in.repeat_divisor  = csr_data[DIV_BITS-1:0];
            REG_TAP_MIN_MS:      cfg_in.tap_min_ms      = csr_data[MS_CFG_BITS-1:0];
            REG_LONG_PRESS_MS:   cfg_in.long_press_ms   = csr_data[MS_CFG_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_threshold <= SWIPE_THRESHOLD_RST;
         cfg_ff.repeat_divisor  <= REPEAT_DIVISOR_RST;
         cfg_ff.tap_min_ms      <= TAP_MIN_MS_RST;
         cfg_ff.long_press_ms   <= LONG_PRESS_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/tstr_dir.sv]
module tstr_dir import tstr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]  x_pos,
   input  logic [COORD_BITS-1:0]  y_pos,
   input  logic [COORD_BITS-1:0]  start_x,
   input  logic [COORD_BITS-1:0]  start_y,
   input  logic [THRESH_BITS-1:0] threshold,
   output logic [EVENT_BITS-1:0]  direction
);

   localparam int CMP_W = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;

   logic [COORD_BITS:0]   dx, dy, ndx, ndy;
   logic [COORD_BITS-1:0] ax, ay;
   logic [CMP_W-1:0]      ax_w, ay_w, thr_w;
   logic                  dx_pos, dy_pos;

   // exact signed offsets, one extra bit so they never wrap
   assign dx  = {1'b0, x_pos} - {1'b0, start_x};
   assign dy  = {1'b0, y_pos} - {1'b0, start_y};
   assign ndx = '0 - dx;
   assign ndy = '0 - dy;
   assign ax  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
   assign ay  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

   assign ax_w  = CMP_W'(ax);
   assign ay_w  = CMP_W'(ay);
   assign thr_w = CMP_W'(threshold);

   assign dx_pos = !dx[COORD_BITS] && (dx != '0);
   assign dy_pos = !dy[COORD_BITS] && (dy != '0);

   always_comb begin
      if (ax_w <= thr_w && ay_w <= thr_w) begin
         direction = EV_NONE;
      end else if (ax > ay) begin
         direction = dx_pos ? EV_RIGHT : EV_LEFT;
      end else begin
         direction = dy_pos ? EV_DOWN : EV_UP;
      end
   end

endmodule

[hw/rtl/tstr_core.sv]
module tstr_core import tstr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_touching,
   input  logic [COORD_BITS-1:0] req_x_pos,
   input  logic [COORD_BITS-1:0] req_y_pos,
   input  logic [TIME_BITS-1:0]  req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [EVENT_BITS-1:0] rsp_event_res
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_BEGIN = 2'd1;
   localparam logic [1:0] PH_TRACK = 2'd2;
   localparam logic [1:0] PH_END   = 2'd3;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_touch_ff;
   logic [COORD_BITS-1:0] in_x_ff, in_y_ff;
   logic [TIME_BITS-1:0]  in_now_ff;

   // recognizer state
   logic [1:0]            phase_ff, phase_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [EVENT_BITS-1:0] last_dir_ff, last_dir_in;
   logic [DIV_BITS-1:0]   count_ff, count_in;
   logic [TIME_BITS-1:0]  mark_ff, mark_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [EVENT_BITS-1:0] event_ff, event_in;

   logic                  advance, step, req_fire;
   logic [EVENT_BITS-1:0] direction;
   logic [DIV_BITS-1:0]   div_eff, count_inc;
   logic [TIME_BITS-1:0]  held;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = event_ff;

   tstr_dir #(
      .COORD_BITS (COORD_BITS)
   ) u_dir (
      .x_pos     (in_x_ff),
      .y_pos     (in_y_ff),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .threshold (cfg.swipe_threshold),
      .direction (direction)
   );

   assign div_eff   = (cfg.repeat_divisor == '0) ? DIV_BITS'(1) : cfg.repeat_divisor;
   assign count_inc = count_ff + DIV_BITS'(1);
   assign held      = in_now_ff - mark_ff;

   always_comb begin
      phase_in    = phase_ff;
      start_x_in  = start_x_ff;
      start_y_in  = start_y_ff;
      last_dir_in = last_dir_ff;
      count_in    = count_ff;
      mark_in     = mark_ff;
      event_in    = EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (in_touch_ff) phase_in = PH_BEGIN;
         end
         PH_BEGIN: begin
            start_x_in = in_x_ff;
            start_y_in = in_y_ff;
            mark_in    = in_now_ff;
            count_in   = '0;
            phase_in   = PH_TRACK;
         end
         default: begin
            if (phase_ff == PH_TRACK && in_touch_ff) begin
               count_in    = (count_inc >= div_eff) ? '0 : count_inc;
               last_dir_in = direction;
               if (direction != EV_NONE) begin
                  mark_in = in_now_ff;
                  if (count_in == '0) event_in = direction;
               end
            end else begin
               // release: tracking without touch, or end phase
               phase_in   = PH_IDLE;
               start_x_in = '0;
               start_y_in = '0;
               if (last_dir_ff == EV_NONE) begin
                  if (held < TIME_BITS'(cfg.long_press_ms)) begin
                     if (held > TIME_BITS'(cfg.tap_min_ms)) event_in = EV_TAP;
                  end else begin
                     event_in = EV_LONG;
                  end
               end
               last_dir_in = EV_NONE;
            end
         end
      endcase
   end

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         last_dir_ff  <= EV_NONE;
         count_ff     <= '0;
         mark_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff    <= phase_in;
            start_x_ff  <= start_x_in;
            start_y_ff  <= start_y_in;
            last_dir_ff <= last_dir_in;
            count_ff    <= count_in;
            mark_ff     <= mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_touch_ff <= req_touching;
         in_x_ff     <= req_x_pos;
         in_y_ff     <= req_y_pos;
         in_now_ff   <= req_now_ms;
      end
      if (step) event_ff <= event_in;
   end

   // a direction is only ever remembered while tracking
   a_dir_in_track: assert property (@(posedge clock) disable iff (reset)
      last_dir_ff != EV_NONE |-> phase_ff == PH_TRACK)
      else $error("direction held outside tracking");

   a_idle_origin: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (start_x_ff == '0 && start_y_ff == '0))
      else $error("start point not cleared in idle");

   a_begin_to_track: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_BEGIN |=> phase_ff == PH_TRACK)
      else $error("begin did not move to tracking");

   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (event_ff == EV_TAP || event_ff == EV_LONG) |-> phase_ff == PH_IDLE)
      else $error("tap or long press without release");

endmodule

[hw/rtl/touch_swipe_tap_recognizer_top.sv]
// A sample's result is shown after its transfer through the input register, then the
//   result register.
// Throughput: one sample per cycle while rsp_ready does not stall the result register.
// Configuration writes are taken every cycle.
// Reset (synchronous, active high) puts the recognizer in idle with cleared state and
//   loads the register defaults.
module touch_swipe_tap_recognizer_top import tstr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_touching,
   input  logic [COORD_BITS-1:0]   req_x_pos,
   input  logic [COORD_BITS-1:0]   req_y_pos,
   input  logic [TIME_BITS-1:0]    req_now_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [EVENT_BITS-1:0]   rsp_event_res,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_data
);

   cfg_type cfg;

   tstr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tstr_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_touching  (req_touching),
      .req_x_pos     (req_x_pos),
      .req_y_pos     (req_y_pos),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res)
   );

endmodule
